### rtl/sshd_pkg.sv
// Package: mode, kind and register index codes and fixed widths for the spike-hold driver.
`default_nettype none

package sshd_pkg;

    localparam int DUR_W     = 16;
    localparam int ELAPSED_W = 17;
    localparam int PCT_W     = 7;
    localparam int DUTY_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
    localparam logic [PCT_W-1:0]     PERCENT_MAX = 7'd100;

    // operating modes
    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_SPIKE = 2'd1;
    localparam logic [1:0] MODE_PWM   = 2'd2;

    // input item kinds
    localparam logic KIND_CMD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPIKE_LEN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPIKE_PCT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_PCT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_LOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_HIGH  = 3'd5;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              pin_level;
        logic              active;
        logic              in_spike;
    } result_t;

endpackage

`default_nettype wire

### rtl/solenoid_spike_hold_driver_unit.sv
// Top level: peak-and-hold solenoid driver with plain, spike-hold and pwm low/high modes.
//
// Usage:
//   s_* channel carries on/off commands (s_tuser = 0) and one-millisecond ticks
//   (s_tuser = 1). Every accepted item yields exactly one result on m_*, which
//   reports the duty, the plain-mode pin level, the on flag and the spike flag
//   as they stand after the item has been applied.
//   cfg_* channel writes the six mode and level registers and is always ready;
//   the user must write it only while no item is in flight; the block does not check.
// Path: each s_ item passes the input register, then the result register, and
//   m_tvalid then rises with its result; a low m_tready can hold it in between.
//   Throughput: one item per cycle while the receiver keeps m_tready high; the
//   limit is the single state update done in the result stage.
// Stall: when m_tready is low the result register holds; the input register
//   still takes one more item, then s_tready drops until the result drains.
// Reset: aresetn (synchronous, active low) clears both stages, all state
//   (output off, hold phase, elapsed count zero, no timeout) and every
//   configuration register to zero.
// Duty levels for spike/hold come from a constant table of 101 entries,
//   floor(p * (2^DUTY_BITS - 1) / 100), built at elaboration.
`default_nettype none

module solenoid_spike_hold_driver_unit
    import sshd_pkg::*;
#(
    parameter int DUTY_BITS = 16  // 8..16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input item channel
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [23:0]          s_tdata,   // [0] turn_on, [16:1] duration_ms
    input  wire logic [0:0]           s_tuser,   // [0] kind
    // result channel
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [23:0]               m_tdata,   // [15:0] duty, [16] pin_level,
                                                 // [17] active, [18] in_spike
    // configuration write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [CFG_DAT_W-1:0] cfg_data
);

    localparam int unsigned FULL_SCALE = (1 << DUTY_BITS) - 1;

    // percent to duty lookup, constant at elaboration
    logic [DUTY_W-1:0] duty_tab [0:100];
    for (genvar g = 0; g <= 100; g++) begin : g_duty_tab
        assign duty_tab[g] = DUTY_W'((g * FULL_SCALE) / 100);
    end

    // configuration registers
    logic [1:0]        mode_reg;
    logic [DUR_W-1:0]  spike_len_reg;
    logic [PCT_W-1:0]  spike_pct_reg;
    logic [PCT_W-1:0]  hold_pct_reg;
    logic [DUTY_W-1:0] duty_low_reg;
    logic [DUTY_W-1:0] duty_high_reg;

    // driver state
    logic                 on_reg, on_next;
    logic                 spike_reg, spike_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic [DUR_W-1:0]     limit_reg, limit_next;

    // input stage
    logic             in_valid_reg;
    logic             in_kind_reg;
    logic             in_turn_on_reg;
    logic [DUR_W-1:0] in_dur_reg;

    // result stage
    logic    m_valid_reg;
    result_t res_reg, res_next;

    logic s_fire;
    logic adv;
    logic adv_fire;

    assign adv      = !m_valid_reg || m_tready;
    assign adv_fire = adv && in_valid_reg;
    assign s_tready = !in_valid_reg || adv;
    assign s_fire   = s_tvalid && s_tready;

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {5'd0, res_reg.in_spike, res_reg.active, res_reg.pin_level,
                        res_reg.duty};

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_PLAIN;
            spike_len_reg <= '0;
            spike_pct_reg <= '0;
            hold_pct_reg  <= '0;
            duty_low_reg  <= '0;
            duty_high_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_addr)
                REG_MODE:      mode_reg      <= cfg_data[1:0];
                REG_SPIKE_LEN: spike_len_reg <= cfg_data;
                REG_SPIKE_PCT: spike_pct_reg <= cfg_data[PCT_W-1:0];
                REG_HOLD_PCT:  hold_pct_reg  <= cfg_data[PCT_W-1:0];
                REG_DUTY_LOW:  duty_low_reg  <= cfg_data;
                REG_DUTY_HIGH: duty_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_kind_reg    <= s_tuser[0];
            in_turn_on_reg <= s_tdata[0];
            in_dur_reg     <= s_tdata[16:1];
        end
    end

    // state update and result for the item in the input register
    logic                 timed;
    logic [ELAPSED_W-1:0] elapsed_inc;
    logic [PCT_W-1:0]     pct_sel;
    logic [PCT_W-1:0]     pct_clamped;

    always_comb begin
        timed        = mode_reg inside {MODE_SPIKE, MODE_PWM};
        on_next      = on_reg;
        spike_next   = spike_reg;
        elapsed_next = elapsed_reg;
        limit_next   = limit_reg;
        elapsed_inc  = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg
                                                    : ELAPSED_W'(elapsed_reg + 1'b1);

        if (in_kind_reg == KIND_CMD) begin
            if (in_turn_on_reg && timed) begin
                spike_next   = (mode_reg == MODE_SPIKE);
                elapsed_next = '0;
                limit_next   = in_dur_reg;
            end
            on_next = in_turn_on_reg;
        end else if (on_reg && timed) begin
            elapsed_next = elapsed_inc;
            if (mode_reg == MODE_SPIKE && spike_reg) begin
                // spike end tick skips the timeout test
                if (elapsed_inc > {1'b0, spike_len_reg}) begin
                    spike_next = 1'b0;
                end
            end else if (!spike_reg) begin
                if (limit_reg != '0 && elapsed_inc > {1'b0, limit_reg}) begin
                    on_next = 1'b0;
                end
            end
        end

        pct_sel     = spike_next ? spike_pct_reg : hold_pct_reg;
        pct_clamped = (pct_sel > PERCENT_MAX) ? PERCENT_MAX : pct_sel;

        res_next.duty = '0;
        case (mode_reg)
            MODE_SPIKE: begin
                if (on_next) begin
                    res_next.duty = duty_tab[pct_clamped];
                end
            end
            MODE_PWM: res_next.duty = on_next ? duty_high_reg : duty_low_reg;
            default:  res_next.duty = '0;
        endcase
        res_next.pin_level = !timed && on_next;
        res_next.active    = on_next;
        res_next.in_spike  = (mode_reg == MODE_SPIKE) && on_next && spike_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            on_reg      <= 1'b0;
            spike_reg   <= 1'b0;
            elapsed_reg <= '0;
            limit_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                m_valid_reg <= in_valid_reg;
            end
            if (adv_fire) begin
                on_reg      <= on_next;
                spike_reg   <= spike_next;
                elapsed_reg <= elapsed_next;
                limit_reg   <= limit_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_fire) begin
            res_reg <= res_next;
        end
    end

`ifndef ASSERT_OFF
    // spike flag only reported while the output is on
    a_spike_needs_active: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(res_reg.in_spike && !res_reg.active))
        else $error("in_spike set while inactive");

    // plain pin level and spike flag belong to different modes
    a_pin_spike_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(res_reg.pin_level && res_reg.in_spike))
        else $error("pin_level and in_spike both set");

    // spike phase starts only from an on command
    a_spike_from_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(spike_reg) |-> $past(adv_fire && in_kind_reg == KIND_CMD))
        else $error("spike phase entered without a command");

    // a new result appears only when an item was waiting in the input stage
    a_result_from_item: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(in_valid_reg))
        else $error("result without an input item");
`endif

endmodule

`default_nettype wire

### verif/solenoid_spike_hold_driver_unit_test.sv
// Testbench: randomized streaming test of the spike-hold solenoid driver against a cycle-free predictor.
`timescale 1ns / 1ps

module solenoid_spike_hold_driver_unit_test;
    import sshd_pkg::*;

    // the unused mode code, which must act like plain on/off
    localparam logic [1:0]  MODE_SPARE  = 2'd3;
    localparam int unsigned DUTY_FULL   = (1 << DUTY_W) - 1;
    localparam int          LONG_STALL  = 400;   // receiver hold-off, cycles
    localparam int          QUIET_LIMIT = 5000;  // cycles without any transfer

    typedef struct packed {
        logic              kind;
        logic              turn_on;
        logic [DUR_W-1:0]  dur_ms;
    } sol_item_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [23:0]          s_tdata   = '0;   // [0] turn_on, [16:1] duration_ms
    logic [0:0]           s_tuser   = '0;   // [0] kind
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [23:0]          m_tdata;          // [15:0] duty, [16] pin_level, [17] active,
                                            // [18] in_spike
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    solenoid_spike_hold_driver_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // stimulus and scoreboard bookkeeping
    sol_item_t   pending_items[$];
    result_t     expected_outputs[$];
    int unsigned n_queued   = 0;
    int unsigned n_accepted = 0;
    int unsigned n_checked  = 0;
    int unsigned n_errors   = 0;
    int unsigned send_gap_pct = 11;
    int unsigned recv_gap_pct = 57;
    int unsigned stalls_asked  = 0;
    int unsigned stalls_served = 0;

    // predictor copy of the registers
    logic [1:0]          cfg_mode;
    logic [DUR_W-1:0]    cfg_spike_len;
    logic [PCT_W-1:0]    cfg_spike_pct;
    logic [PCT_W-1:0]    cfg_hold_pct;
    logic [DUTY_W-1:0]   cfg_duty_low;
    logic [DUTY_W-1:0]   cfg_duty_high;
    // predictor copy of the driver state
    logic                sol_on;
    logic                sol_spike;
    logic [ELAPSED_W-1:0] sol_elapsed;
    logic [DUR_W-1:0]    sol_limit;

    // Applies one command or tick to the predicted state and returns the outputs after it.
    function automatic result_t predict_solenoid(logic kind, logic turn_on,
                                                 logic [DUR_W-1:0] dur);
        result_t     r;
        logic        timed;
        int unsigned pct;
        timed = (cfg_mode == MODE_SPIKE) || (cfg_mode == MODE_PWM);
        if (kind == KIND_CMD) begin
            // a fresh switch-on restarts timing only in the timed modes
            if (turn_on && timed) begin
                sol_spike   = (cfg_mode == MODE_SPIKE);
                sol_elapsed = '0;
                sol_limit   = dur;
            end
            sol_on = turn_on;
        end else if (sol_on && timed) begin
            if (sol_elapsed != ELAPSED_MAX)
                sol_elapsed = sol_elapsed + 1'b1;
            if (cfg_mode == MODE_SPIKE && sol_spike) begin
                // spike end; no timeout test on this tick
                if (sol_elapsed > {1'b0, cfg_spike_len})
                    sol_spike = 1'b0;
            end else if (!sol_spike) begin
                if (sol_limit != '0 && sol_elapsed > {1'b0, sol_limit})
                    sol_on = 1'b0;
            end
            // pwm with a leftover spike flag: timeout not tested
        end
        r.duty = '0;
        if (cfg_mode == MODE_SPIKE) begin
            if (sol_on) begin
                pct = sol_spike ? cfg_spike_pct : cfg_hold_pct;
                if (pct > PERCENT_MAX)
                    pct = PERCENT_MAX;
                r.duty = DUTY_W'((pct * DUTY_FULL) / 100);
            end
        end else if (cfg_mode == MODE_PWM) begin
            r.duty = sol_on ? cfg_duty_high : cfg_duty_low;
        end
        r.pin_level = !timed && sol_on;
        r.active    = sol_on;
        r.in_spike  = (cfg_mode == MODE_SPIKE) && sol_on && sol_spike;
        return r;
    endfunction

    // Driver: presents queued items, with random gaps between transfers.
    always @(posedge aclk) begin
        sol_item_t cur;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                cur = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= cur.kind;
                s_tdata  <= {7'd0, cur.dur_ms, cur.turn_on};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver backpressure; a requested long hold-off is counted down here.
    always @(posedge aclk) begin
        int stall_left;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left = 0;
        end else begin
            if (stalls_served != stalls_asked && stall_left == 0) begin
                stall_left    = LONG_STALL;
                stalls_served = stalls_served + 1;
            end
            if (stall_left != 0) begin
                stall_left = stall_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_gap_pct);
            end
        end
    end

    // Monitor: tracks register writes, predicts each accepted item, checks each result.
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            cfg_mode      = MODE_PLAIN;
            cfg_spike_len = '0;
            cfg_spike_pct = '0;
            cfg_hold_pct  = '0;
            cfg_duty_low  = '0;
            cfg_duty_high = '0;
            sol_on        = 1'b0;
            sol_spike     = 1'b0;
            sol_elapsed   = '0;
            sol_limit     = '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    REG_MODE:      cfg_mode      = cfg_data[1:0];
                    REG_SPIKE_LEN: cfg_spike_len = cfg_data;
                    REG_SPIKE_PCT: cfg_spike_pct = cfg_data[PCT_W-1:0];
                    REG_HOLD_PCT:  cfg_hold_pct  = cfg_data[PCT_W-1:0];
                    REG_DUTY_LOW:  cfg_duty_low  = cfg_data;
                    REG_DUTY_HIGH: cfg_duty_high = cfg_data;
                    default: ;
                endcase
            end
            // check before predicting, so a stray result never meets a fresh expectation
            if (m_tvalid && m_tready) begin
                if (expected_outputs.size() == 0) begin
                    $error("result transfer with nothing expected: tdata %06h", m_tdata);
                    n_errors = n_errors + 1;
                end else begin
                    want = expected_outputs.pop_front();
                    n_checked = n_checked + 1;
                    if (m_tdata[15:0] !== want.duty) begin
                        $error("duty: expected %04h, got %04h", want.duty, m_tdata[15:0]);
                        n_errors = n_errors + 1;
                    end
                    if (m_tdata[16] !== want.pin_level) begin
                        $error("pin_level: expected %b, got %b", want.pin_level, m_tdata[16]);
                        n_errors = n_errors + 1;
                    end
                    if (m_tdata[17] !== want.active) begin
                        $error("active: expected %b, got %b", want.active, m_tdata[17]);
                        n_errors = n_errors + 1;
                    end
                    if (m_tdata[18] !== want.in_spike) begin
                        $error("in_spike: expected %b, got %b", want.in_spike, m_tdata[18]);
                        n_errors = n_errors + 1;
                    end
                    if (m_tdata[23:19] !== 5'd0) begin
                        $error("padding: expected 00, got %02h", m_tdata[23:19]);
                        n_errors = n_errors + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_outputs.push_back(predict_solenoid(s_tuser[0], s_tdata[0],
                                                            s_tdata[16:1]));
                n_accepted = n_accepted + 1;
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge aclk) begin
        int quiet;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet = quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic push_item(logic kind, logic turn_on, logic [DUR_W-1:0] dur);
        sol_item_t it;
        it.kind    = kind;
        it.turn_on = turn_on;
        it.dur_ms  = dur;
        pending_items.push_back(it);
        n_queued = n_queued + 1;
    endtask

    // ticks carry random content in the fields the block ignores
    task automatic push_ticks(int n);
        repeat (n) push_item(KIND_TICK, 1'($urandom), 16'($urandom));
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Sender holds back until every queued item has produced its result.
    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_items.size() != 0 || n_accepted != n_queued || n_checked != n_accepted);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [DUTY_W-1:0] pick_level();
        int unsigned roll;
        roll = $urandom_range(5);
        if (roll == 0)
            return '0;
        else if (roll == 1)
            return '1;
        return DUTY_W'($urandom);
    endfunction

    task automatic pick_settings();
        int unsigned roll;
        logic [1:0]  m;
        roll = $urandom_range(99);
        if (roll < 40)
            m = MODE_SPIKE;
        else if (roll < 75)
            m = MODE_PWM;
        else if (roll < 90)
            m = MODE_PLAIN;
        else
            m = MODE_SPARE;
        write_reg(REG_MODE, {14'd0, m});
        // mostly short spikes so the hold phase and timeout are reached
        roll = $urandom_range(9);
        if (roll < 8)
            write_reg(REG_SPIKE_LEN, 16'($urandom_range(6)));
        else if (roll == 8)
            write_reg(REG_SPIKE_LEN, 16'hFFFF);
        else
            write_reg(REG_SPIKE_LEN, 16'($urandom));
        write_reg(REG_SPIKE_PCT, 16'($urandom_range($urandom_range(3) != 0 ? 100 : 127)));
        write_reg(REG_HOLD_PCT,  16'($urandom_range($urandom_range(3) != 0 ? 100 : 127)));
        write_reg(REG_DUTY_LOW,  pick_level());
        write_reg(REG_DUTY_HIGH, pick_level());
    endtask

    // Mostly switch-on, a run of ticks, maybe switch-off; the rest is raw noise.
    task automatic push_sequence();
        int unsigned      roll;
        logic [DUR_W-1:0] dur;
        roll = $urandom_range(99);
        if (roll < 80) begin
            if ($urandom_range(7) == 0)
                dur = DUR_W'($urandom);
            else
                dur = DUR_W'($urandom_range(10));
            push_item(KIND_CMD, 1'b1, dur);
            push_ticks($urandom_range(14));
            if ($urandom_range(1) == 1)
                push_item(KIND_CMD, 1'b0, DUR_W'($urandom));
        end else begin
            repeat ($urandom_range(3, 1))
                push_item(1'($urandom), 1'($urandom), DUR_W'($urandom));
        end
    endtask

    initial begin
        int phase;
        int seg;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // plain mode straight out of reset
        push_item(KIND_CMD, 1'b1, 16'hFFFF);
        push_ticks(1);
        push_item(KIND_CMD, 1'b0, 16'h0000);
        wait_drained();

        // spike-hold, hold percent over full scale, duration shorter than spike
        write_reg(REG_MODE, {14'd0, MODE_SPIKE});
        write_reg(REG_SPIKE_LEN, 16'd2);
        write_reg(REG_SPIKE_PCT, 16'd100);
        write_reg(REG_HOLD_PCT, 16'd127);
        write_reg(REG_DUTY_LOW, 16'h0000);
        write_reg(REG_DUTY_HIGH, 16'hFFFF);
        push_item(KIND_CMD, 1'b1, 16'd1);
        push_ticks(5);
        // off during spike keeps the spike flag; tick while off does nothing
        push_item(KIND_CMD, 1'b1, 16'd0);
        push_ticks(1);
        push_item(KIND_CMD, 1'b0, 16'd0);
        push_ticks(1);
        push_item(KIND_CMD, 1'b1, 16'd1);
        push_ticks(1);
        wait_drained();

        // switch to pwm while on with the spike flag still set: no timeout
        write_reg(REG_MODE, {14'd0, MODE_PWM});
        push_ticks(3);
        wait_drained();

        // spare mode code behaves as plain on/off
        write_reg(REG_MODE, {14'd0, MODE_SPARE});
        push_ticks(1);
        push_item(KIND_CMD, 1'b0, 16'd0);
        push_item(KIND_CMD, 1'b1, 16'd5);
        wait_drained();

        // pwm with swapped extremes and a short timeout
        write_reg(REG_MODE, {14'd0, MODE_PWM});
        write_reg(REG_DUTY_LOW, 16'hFFFF);
        write_reg(REG_DUTY_HIGH, 16'h0000);
        push_item(KIND_CMD, 1'b0, 16'd0);
        push_item(KIND_CMD, 1'b1, 16'd2);
        push_ticks(3);
        wait_drained();

        // random part: receiver-heavy gaps, then sender-heavy, then none
        for (phase = 0; phase < 3; phase++) begin
            send_gap_pct = (phase == 0) ? 11 : (phase == 1) ? 57 : 0;
            recv_gap_pct = (phase == 0) ? 57 : (phase == 1) ? 11 : 0;
            for (seg = 0; seg < 9; seg++) begin
                pick_settings();
                // one long receiver hold-off while the sender keeps offering
                if (phase == 0 && seg == 3)
                    stalls_asked = stalls_asked + 1;
                repeat (4) push_sequence();
                wait_drained();
                repeat (4) push_sequence();
                wait_drained();
            end
        end

        // spike flag left set in pwm mode, then back to spike
        write_reg(REG_MODE, {14'd0, MODE_SPIKE});
        write_reg(REG_SPIKE_LEN, 16'hFFFF);
        push_item(KIND_CMD, 1'b1, 16'd0);
        wait_drained();
        write_reg(REG_MODE, {14'd0, MODE_PWM});
        push_ticks(20);
        wait_drained();
        write_reg(REG_MODE, {14'd0, MODE_SPIKE});
        push_ticks(1);
        push_item(KIND_CMD, 1'b0, 16'd0);
        wait_drained();
        repeat (8) @(posedge aclk);

        if (n_errors == 0 && expected_outputs.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### sim.f
rtl/sshd_pkg.sv
rtl/solenoid_spike_hold_driver_unit.sv
verif/solenoid_spike_hold_driver_unit_test.sv
